>>> rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared codes and constants of the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned PCOUNT_W  = 11;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 2'd1;

endpackage

>>> rtl/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/bpa_scan.sv
// ----------------------------------------------------------------------------
// bpa_scan
// Evaluates one 32-page bitmap word of the next-fit run search.
// ----------------------------------------------------------------------------
module bpa_scan
  import bpa_pkg::*;
#(
  parameter int unsigned CW = 11,
  parameter int unsigned XW = 17
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [XW-1:0]        base_i,
  input  logic [XW-1:0]        start_i,
  input  logic [CW-1:0]        limit_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic [CW-1:0]        need_i,
  output logic                 found_o,
  output logic [XW-1:0]        pos_o,
  output logic [CW-1:0]        cnt_o
);

  localparam int unsigned LW = CW + 6;

  logic [WORD_BITS-1:0] used;
  logic [LW-1:0]        len [WORD_BITS];

  // A page counts as used when its bitmap bit is set, when it lies before the
  // search start, or when it lies at or past the end of the pool.
  always_comb begin
    logic [XW-1:0] g;
    for (int j = 0; j < WORD_BITS; j++) begin
      g = base_i + XW'(j);
      used[j] = word_i[j] || (g < start_i) || (g >= XW'(limit_i));
    end
  end

  // Length of the free run that ends at each bit, carrying the run from
  // earlier words when the word is free up to that bit.
  always_comb begin
    logic          au;
    logic [BIT_W-1:0] lu;
    for (int j = 0; j < WORD_BITS; j++) begin
      au = 1'b0;
      lu = '0;
      for (int k = 0; k <= j; k++) begin
        if (used[k]) begin
          au = 1'b1;
          lu = BIT_W'(k);
        end
      end
      if (used[j]) begin
        len[j] = '0;
      end else if (au) begin
        len[j] = LW'(BIT_W'(j) - lu);
      end else begin
        len[j] = LW'(cnt_i) + LW'(j + 1);
      end
    end
  end

  always_comb begin
    found_o = 1'b0;
    pos_o   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (len[j] >= LW'(need_i)) begin
        found_o = 1'b1;
        pos_o   = base_i + XW'(j + 1) - XW'(need_i);
      end
    end
    cnt_o = CW'(len[WORD_BITS-1]);
  end

endmodule

>>> rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Next-fit page allocator over a page bitmap and a run length table.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o kind_i, request_bytes_i, free_address_i
// out      output     out_valid_o/out_stall_i status_o, block_address_o, run_pages_o,
//                                           used_pages_o, idle_pages_o
// cfg      input      cfg_we_i              cfg_index_i, cfg_data_i
//
// An allocate scans one 32-page bitmap word per cycle from the hint up to the end
// of the pool, then does a read-modify-write (S_MRD, then S_MWR) for each bitmap word of
// the run; a failed pass, or a hint at or past the pool end, scans from page 0.
// A free reads the run table (S_FRD) and then clears its run the same way.
// Too-large and not-owned items go straight to S_DONE, a not-allocated free after S_FRD.
// After reset both memories are cleared with in_stall_o high.
// A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned POOL_PAGES = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 kind_i,
  input  logic [BYTES_W-1:0]   request_bytes_i,
  input  logic [ADDR_W-1:0]    free_address_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [ADDR_W-1:0]    block_address_o,
  output logic [PCOUNT_W-1:0]  run_pages_o,
  output logic [PCOUNT_W-1:0]  used_pages_o,
  output logic [PCOUNT_W-1:0]  idle_pages_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned PW     = $clog2(POOL_PAGES);
  localparam int unsigned CW     = $clog2(POOL_PAGES + 1);
  localparam int unsigned XW     = PW + 7;
  localparam int unsigned NWORDS = (POOL_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned SHIFT  = $clog2(PAGE_BYTES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MRD  = 3'd3;
  localparam logic [2:0] S_MWR  = 3'd4;
  localparam logic [2:0] S_FRD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [PW-1:0]       clr_q, clr_d;
  logic [ADDR_W-1:0]   pool_base_q;
  logic [PCOUNT_W-1:0] pool_pages_q;
  logic [CW-1:0]       hint_q, hint_d;
  logic [CW-1:0]       used_q, used_d;
  logic [CW-1:0]       limit_q, limit_d;
  logic                kind_q, kind_d;
  logic                pass_q, pass_d;
  logic [WAW-1:0]      w_q, w_d;
  logic [XW-1:0]       start_q, start_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       n_q, n_d;
  logic [XW-1:0]       lo_q, lo_d;
  logic [XW-1:0]       hi_q, hi_d;
  logic [PW-1:0]       pg_q, pg_d;
  logic [STATUS_W-1:0] st_q, st_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_st_q;
  logic [ADDR_W-1:0]   out_addr_q;
  logic [CW-1:0]       out_run_q;
  logic [CW-1:0]       out_used_q;
  logic [CW-1:0]       out_idle_q;
  logic                out_load;

  logic                bm_we, rl_we;
  logic [WAW-1:0]      bm_waddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic [PW-1:0]       rl_waddr, rl_raddr;
  logic [CW-1:0]       rl_wdata, rl_rdata;

  logic                sc_found;
  logic [XW-1:0]       sc_pos;
  logic [CW-1:0]       sc_cnt;

  logic [CW-1:0]       lim_now;
  logic [ADDR_W-1:0]   delta;
  logic [ADDR_W-1:0]   pg_full;
  logic                owned;
  logic [BYTES_W-1:0]  bytes_m1;
  logic [BYTES_W:0]    need_pages;
  logic [XW-1:0]       base;
  logic [XW-1:0]       next_base;
  logic [XW-1:0]       free_end;
  logic [WORD_BITS-1:0] run_mask;
  logic                in_xfer, out_xfer;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign lim_now = (32'(pool_pages_q) < POOL_PAGES) ? CW'(pool_pages_q) : CW'(POOL_PAGES);

  assign delta   = free_address_i - pool_base_q;
  assign pg_full = delta >> SHIFT;
  assign owned   = (delta[SHIFT-1:0] == '0) && (pg_full < ADDR_W'(lim_now));

  assign bytes_m1   = (request_bytes_i == '0) ? '0 : request_bytes_i - 1'b1;
  assign need_pages = (BYTES_W+1)'(bytes_m1 >> SHIFT) + 1'b1;

  assign base      = XW'(w_q) << BIT_W;
  assign next_base = (XW'(w_q) + 1'b1) << BIT_W;
  assign free_end  = (XW'(pg_q) + XW'(rl_rdata) > XW'(POOL_PAGES)) ?
                     XW'(POOL_PAGES) : XW'(pg_q) + XW'(rl_rdata);

  always_comb begin
    logic [XW-1:0] g;
    for (int j = 0; j < WORD_BITS; j++) begin
      g = base + XW'(j);
      run_mask[j] = (g >= lo_q) && (g < hi_q);
    end
  end

  bpa_scan #(
    .CW (CW),
    .XW (XW)
  ) u_scan (
    .word_i  (bm_rdata),
    .base_i  (base),
    .start_i (start_q),
    .limit_i (limit_q),
    .cnt_i   (cnt_q),
    .need_i  (n_q),
    .found_o (sc_found),
    .pos_o   (sc_pos),
    .cnt_o   (sc_cnt)
  );

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .raddr_i (w_d),
    .rdata_o (bm_rdata)
  );

  bpa_ram #(
    .WIDTH (CW),
    .DEPTH (POOL_PAGES)
  ) u_runlen (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (rl_waddr),
    .wdata_i (rl_wdata),
    .raddr_i (rl_raddr),
    .rdata_o (rl_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    hint_d      = hint_q;
    used_d      = used_q;
    limit_d     = limit_q;
    kind_d      = kind_q;
    pass_d      = pass_q;
    w_d         = w_q;
    start_d     = start_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pg_d        = pg_q;
    st_d        = st_q;
    out_load    = 1'b0;
    bm_we       = 1'b0;
    bm_waddr    = w_q;
    bm_wdata    = '0;
    rl_we       = 1'b0;
    rl_waddr    = pg_q;
    rl_wdata    = '0;
    rl_raddr    = PW'(pg_full);

    unique case (state_q)
      S_CLR: begin
        bm_we    = (32'(clr_q) < NWORDS);
        bm_waddr = WAW'(clr_q);
        rl_we    = 1'b1;
        rl_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (32'(clr_q) == POOL_PAGES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          kind_d  = kind_i;
          limit_d = lim_now;
          st_d    = ST_OK;
          n_d     = '0;
          if (kind_i == KIND_ALLOC) begin
            n_d     = CW'(need_pages);
            pass_d  = 1'b0;
            cnt_d   = '0;
            start_d = XW'(hint_q);
            w_d     = WAW'(XW'(hint_q) >> BIT_W);
            if (need_pages > (BYTES_W+1)'(POOL_PAGES)) begin
              st_d    = ST_TOO_LARGE;
              state_d = S_DONE;
            end else if (hint_q >= lim_now) begin
              // The pass from the hint cannot find anything, so go to page 0.
              pass_d  = 1'b1;
              hint_d  = '0;
              start_d = '0;
              w_d     = '0;
              state_d = S_SCAN;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            pg_d = PW'(pg_full);
            if (!owned) begin
              st_d    = ST_NOT_OWNED;
              state_d = S_DONE;
            end else begin
              state_d = S_FRD;
            end
          end
        end
      end
      S_SCAN: begin
        if (sc_found) begin
          lo_d     = sc_pos;
          hi_d     = sc_pos + XW'(n_q);
          hint_d   = CW'(sc_pos + XW'(n_q));
          used_d   = used_q + n_q;
          rl_we    = 1'b1;
          rl_waddr = PW'(sc_pos);
          rl_wdata = n_q;
          w_d      = WAW'(sc_pos >> BIT_W);
          state_d  = S_MRD;
        end else if (next_base >= XW'(limit_q)) begin
          if (!pass_q) begin
            // The pass from the hint failed: retry once from page 0.
            pass_d  = 1'b1;
            hint_d  = '0;
            start_d = '0;
            cnt_d   = '0;
            w_d     = '0;
          end else begin
            hint_d  = '0;
            st_d    = ST_NO_SPACE;
            state_d = S_DONE;
          end
        end else begin
          cnt_d = sc_cnt;
          w_d   = w_q + 1'b1;
        end
      end
      S_FRD: begin
        if (rl_rdata == '0) begin
          st_d    = ST_NOT_ALLOC;
          state_d = S_DONE;
        end else begin
          n_d      = rl_rdata;
          lo_d     = XW'(pg_q);
          hi_d     = free_end;
          used_d   = (used_q >= rl_rdata) ? used_q - rl_rdata : '0;
          rl_we    = 1'b1;
          rl_waddr = pg_q;
          rl_wdata = '0;
          w_d      = WAW'(XW'(pg_q) >> BIT_W);
          state_d  = S_MRD;
        end
      end
      S_MRD: begin
        state_d = S_MWR;
      end
      S_MWR: begin
        bm_we    = 1'b1;
        bm_waddr = w_q;
        bm_wdata = (kind_q == KIND_ALLOC) ? (bm_rdata | run_mask) : (bm_rdata & ~run_mask);
        if (next_base >= hi_q) begin
          state_d = S_DONE;
        end else begin
          w_d     = w_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_xfer ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      pool_base_q  <= '0;
      pool_pages_q <= '0;
      hint_q       <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_POOL_BASE) begin
          pool_base_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_POOL_PAGES) begin
          pool_pages_q <= cfg_data_i[PCOUNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    kind_q  <= kind_d;
    pass_q  <= pass_d;
    w_q     <= w_d;
    start_q <= start_d;
    cnt_q   <= cnt_d;
    n_q     <= n_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    pg_q    <= pg_d;
    st_q    <= st_d;
    if (out_load) begin
      out_st_q   <= st_q;
      out_addr_q <= (kind_q == KIND_ALLOC && st_q == ST_OK) ?
                    pool_base_q + (ADDR_W'(lo_q) << SHIFT) : '0;
      out_run_q  <= (st_q == ST_OK) ? n_q : '0;
      out_used_q <= used_q;
      out_idle_q <= (limit_q > used_q) ? limit_q - used_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign block_address_o = out_addr_q;
  assign run_pages_o     = PCOUNT_W'(out_run_q);
  assign used_pages_o    = PCOUNT_W'(out_used_q);
  assign idle_pages_o    = PCOUNT_W'(out_idle_q);

  // A new result only appears right after an item has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished item");

  // The page count never exceeds the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= POOL_PAGES)
    else $error("used page count out of range");

  // The bitmap is never written while it is being searched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !bm_we)
    else $error("bitmap written during a search");

  // A successful result always carries a nonzero run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_st_q == ST_OK |-> out_run_q != '0)
    else $error("successful result without pages");

endmodule
